// File: hdl/sms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants for the spin mode and armor selector
// Field widths, register indexes, the mode type and the queue entry layout.
// ----------------------------------------------------------------------------
package sms_pkg;

    // armor slots
    localparam int MAX_ARMORS    = 4;
    localparam int OFFSET_FIELDS = 4;
    localparam int ACTIVE_SLOTS  = (MAX_ARMORS < OFFSET_FIELDS) ? MAX_ARMORS : OFFSET_FIELDS;

    // field widths
    localparam int OFF_W    = 15;
    localparam int MAG_W    = 15;
    localparam int CNT_W    = 3;
    localparam int RATE_W   = 16;
    localparam int ARATE_W  = 16;
    localparam int IDX_W    = 2;
    localparam int LOCK_W   = 3;
    localparam int STREAK_W = 8;
    localparam int RATECFG_W = 15;
    localparam int ANGCFG_W  = 14;

    // stream widths
    localparam int IN_BITS    = OFFSET_FIELDS * OFF_W + CNT_W + RATE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_ENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ENTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HALF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_WINDOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_LIMIT = 3'd6;

    // special values
    localparam logic [LOCK_W-1:0]   NO_LOCK    = 3'd7;
    localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_SLOW   = 2'd0,
        MODE_SPIN   = 2'd1,
        MODE_CENTER = 2'd2
    } t_mode;

    typedef struct packed {
        logic [RATECFG_W-1:0] spin_enter_rate;
        logic [RATECFG_W-1:0] center_enter_rate;
        logic [ANGCFG_W-1:0]  view_half_angle;
        logic [ANGCFG_W-1:0]  switch_margin;
        logic [ANGCFG_W-1:0]  approach_limit;
        logic [ANGCFG_W-1:0]  leave_window;
        logic [STREAK_W-1:0]  confirm_limit;
    } t_cfg;

    // classified request, state independent
    typedef struct packed {
        logic             no_armor;
        logic [IDX_W-1:0] near_idx;
        logic [1:0]       cand_cnt;
        logic [IDX_W-1:0] cand0;
        logic [IDX_W-1:0] cand1;
        logic [MAG_W-1:0] cand0_mag;
        logic [MAG_W-1:0] cand1_mag;
        logic [IDX_W-1:0] spin_pick;
        logic             above_spin;
        logic             below_spin;
        logic             above_center;
        logic             below_center;
    } t_item;

endpackage
`default_nettype wire

// File: hdl/sms_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_front: request classifier
// Unpacks one target update and reduces it to candidates, the nearest armor,
// the spinning-mode pick and the rate threshold flags.
// ----------------------------------------------------------------------------
module sms_front (
    input  wire logic [sms_pkg::IN_DATA_W-1:0] i_tdata,
    input  wire sms_pkg::t_cfg                 i_cfg,
    output sms_pkg::t_item                     o_item
);
    import sms_pkg::*;

    logic signed [OFF_W-1:0] w_off [OFFSET_FIELDS];
    logic [MAG_W-1:0]        w_mag [OFFSET_FIELDS];
    logic [CNT_W-1:0]        w_count;
    logic [CNT_W-1:0]        w_n;
    logic signed [RATE_W-1:0] w_rate;
    logic [ARATE_W-1:0]      w_arate;
    logic                    w_rate_pos;
    logic                    w_rate_neg;

    // unpack and take magnitudes
    always_comb begin
        for (int i = 0; i < OFFSET_FIELDS; i++) begin
            w_off[i] = i_tdata[i*OFF_W +: OFF_W];
            w_mag[i] = w_off[i][OFF_W-1] ? MAG_W'(~w_off[i] + 1'b1) : MAG_W'(w_off[i]);
        end
    end

    assign w_count = i_tdata[OFFSET_FIELDS*OFF_W +: CNT_W];
    assign w_n     = (w_count > CNT_W'(ACTIVE_SLOTS)) ? CNT_W'(ACTIVE_SLOTS) : w_count;
    assign w_rate  = i_tdata[OFFSET_FIELDS*OFF_W + CNT_W +: RATE_W];
    assign w_arate = w_rate[RATE_W-1] ? ARATE_W'(~w_rate + 1'b1) : ARATE_W'(w_rate);
    assign w_rate_neg = w_rate[RATE_W-1];
    assign w_rate_pos = !w_rate[RATE_W-1] && (w_rate != '0);

    // nearest, view candidates and spinning pick
    always_comb begin
        logic [IDX_W-1:0] best;
        logic [MAG_W-1:0] best_mag;
        logic [1:0]       nc;
        logic             found;
        logic             act;
        logic             in_win;

        best     = '0;
        best_mag = w_mag[0];
        nc       = '0;
        found    = 1'b0;
        o_item   = '0;

        for (int i = 0; i < OFFSET_FIELDS; i++) begin
            act = (CNT_W'(i) < w_n);
            // nearest, lowest index on a tie
            if (act && (w_mag[i] < best_mag)) begin
                best     = IDX_W'(i);
                best_mag = w_mag[i];
            end
            // first two in-view armors
            if (act && (w_mag[i] <= MAG_W'(i_cfg.view_half_angle))) begin
                if (nc == 2'd0) begin
                    o_item.cand0     = IDX_W'(i);
                    o_item.cand0_mag = w_mag[i];
                    nc = 2'd1;
                end else if (nc == 2'd1) begin
                    o_item.cand1     = IDX_W'(i);
                    o_item.cand1_mag = w_mag[i];
                    nc = 2'd2;
                end
            end
            // approaching side inside the leave window
            in_win = (w_mag[i] <= MAG_W'(i_cfg.approach_limit))
                  && (w_mag[i] < MAG_W'(i_cfg.leave_window))
                  && ((w_rate_pos && !w_off[i][OFF_W-1] && (w_off[i] != '0))
                   || (w_rate_neg && w_off[i][OFF_W-1]));
            if (act && !found && in_win) begin
                o_item.spin_pick = IDX_W'(i);
                found = 1'b1;
            end
        end

        if (!found) begin
            o_item.spin_pick = best;
        end
        o_item.near_idx     = best;
        o_item.cand_cnt     = nc;
        o_item.no_armor     = (w_n == '0);
        o_item.above_spin   = w_arate > ARATE_W'(i_cfg.spin_enter_rate);
        o_item.below_spin   = w_arate < ARATE_W'(i_cfg.spin_enter_rate);
        o_item.above_center = w_arate > ARATE_W'(i_cfg.center_enter_rate);
        o_item.below_center = w_arate < ARATE_W'(i_cfg.center_enter_rate);
    end

endmodule
`default_nettype wire

// File: hdl/sms_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_queue: two-entry request queue
// Decouples the classifier from the mode machine; push and pop may coincide.
// ----------------------------------------------------------------------------
module sms_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sms_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output sms_pkg::t_item      o_item
);
    import sms_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: hdl/sms_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_back: armor lock and spin mode machine
// Resolves the sticky slow-mode lock, advances the three-mode machine and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module sms_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sms_pkg::t_cfg  i_cfg,
    input  wire logic           i_empty,
    input  wire sms_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [sms_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                o_tuser
);
    import sms_pkg::*;

    t_mode               r_mode;
    t_mode               n_mode;
    logic [LOCK_W-1:0]   r_lock;
    logic [LOCK_W-1:0]   n_lock;
    logic [STREAK_W-1:0] r_streak;
    logic [STREAK_W-1:0] n_streak;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_pick;
    logic                r_aim;
    t_mode               r_mode_out;
    logic                r_no_armor;
    logic [IDX_W-1:0]    n_pick;

    assign o_pop   = !i_empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_tdata = {3'b000, r_mode_out, r_aim, r_pick};
    assign o_tuser = r_no_armor;

    // pick, lock and next mode
    always_comb begin
        logic [STREAK_W-1:0] bumped;
        logic [IDX_W-1:0]    other;
        logic [MAG_W-1:0]    other_mag;
        logic [MAG_W-1:0]    lock_mag;
        logic                lock_is0;

        n_mode    = r_mode;
        n_lock    = r_lock;
        n_streak  = r_streak;
        n_pick    = '0;
        bumped    = (r_streak == STREAK_MAX) ? STREAK_MAX : r_streak + 1'b1;
        other     = '0;
        other_mag = '0;
        lock_mag  = '0;
        lock_is0  = 1'b0;

        if (!i_item.no_armor) begin
            unique case (r_mode)
                MODE_SLOW: begin
                    if (i_item.cand_cnt == 2'd0) begin
                        n_lock = NO_LOCK;
                        n_pick = i_item.near_idx;
                    end else if (i_item.cand_cnt == 2'd1) begin
                        n_lock = NO_LOCK;
                        n_pick = i_item.cand0;
                    end else begin
                        // keep a held lock, else take the nearer candidate
                        if (r_lock == {1'b0, i_item.cand0}) begin
                            lock_is0 = 1'b1;
                        end else if (r_lock == {1'b0, i_item.cand1}) begin
                            lock_is0 = 1'b0;
                        end else begin
                            lock_is0 = i_item.cand0_mag < i_item.cand1_mag;
                        end
                        other     = lock_is0 ? i_item.cand1 : i_item.cand0;
                        other_mag = lock_is0 ? i_item.cand1_mag : i_item.cand0_mag;
                        lock_mag  = lock_is0 ? i_item.cand0_mag : i_item.cand1_mag;
                        n_pick    = lock_is0 ? i_item.cand0 : i_item.cand1;
                        // hysteresis against stealing the lock
                        if (({1'b0, other_mag} + {2'b00, i_cfg.switch_margin})
                                < {1'b0, lock_mag}) begin
                            n_pick = other;
                        end
                        n_lock = {1'b0, n_pick};
                    end
                    if (i_item.above_spin) begin
                        n_streak = bumped;
                    end else begin
                        n_streak = '0;
                    end
                    if (n_streak > i_cfg.confirm_limit) begin
                        n_mode   = MODE_SPIN;
                        n_streak = '0;
                        n_lock   = NO_LOCK;
                    end
                end
                MODE_SPIN: begin
                    n_pick = i_item.spin_pick;
                    if (i_item.above_center) begin
                        n_streak = bumped;
                        if (bumped > i_cfg.confirm_limit) begin
                            n_mode   = MODE_CENTER;
                            n_streak = '0;
                        end
                    end else if (i_item.below_spin) begin
                        n_streak = bumped;
                        if (bumped > i_cfg.confirm_limit) begin
                            n_mode   = MODE_SLOW;
                            n_streak = '0;
                            n_lock   = NO_LOCK;
                        end
                    end else begin
                        n_streak = '0;
                    end
                end
                MODE_CENTER: begin
                    n_pick = i_item.near_idx;
                    if (i_item.below_center) begin
                        n_streak = bumped;
                        if (bumped > i_cfg.confirm_limit) begin
                            n_mode   = MODE_SPIN;
                            n_streak = '0;
                        end
                    end else begin
                        n_streak = '0;
                    end
                end
                default: begin
                    n_pick = i_item.near_idx;
                end
            endcase
        end
    end

    // mode machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SLOW;
            r_lock   <= NO_LOCK;
            r_streak <= '0;
        end else if (o_pop) begin
            r_mode   <= n_mode;
            r_lock   <= n_lock;
            r_streak <= n_streak;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pick     <= n_pick;
            r_aim      <= (r_mode == MODE_CENTER);
            r_mode_out <= n_mode;
            r_no_armor <= i_item.no_armor;
        end
    end

endmodule
`default_nettype wire

// File: hdl/spin_mode_and_armor_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spin_mode_and_armor_select: armor selector with a three-mode spin machine
// Each request is one target update; each result names the armor to aim at
// and the tracking mode (slow, spinning, centre) after the update.
//
// s_axis_*: target updates, four Q3.12 offsets, armor count, Q8.8 spin rate.
// m_axis_*: one result per request; tuser flags an update with no armors.
// i_cfg_*:  register writes, taken whenever i_cfg_we is high, meant for idle.
//
// One request per cycle is sustained while m_axis_tready is high: the
// classifier feeds a two-entry queue and the mode machine drains one
// entry per cycle into an output register, so each side stalls
// on its own. When the receiver holds m_axis_tready low, the result register
// and then the queue fill, and s_axis_tready drops once both are full.
// Reset (synchronous, active low) empties the queue and result register,
// loads the default thresholds and puts the machine into slow mode with no
// armor lock and a zero streak.
// ----------------------------------------------------------------------------
module spin_mode_and_armor_select (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // offset_a, offset_b, offset_c, offset_d, armor_count, spin_rate, zero pad
    input  wire logic [sms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // chosen_armor, aim_at_center, mode_now, zero pad
    output logic [sms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // no_armor
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            i_cfg_we,
    input  wire logic [sms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sms_pkg::*;

    t_cfg  r_cfg;
    t_item w_front_item;
    t_item w_queue_item;
    logic  w_full;
    logic  w_empty;
    logic  w_pop;
    logic  w_push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spin_enter_rate   <= 15'd1536;
            r_cfg.center_enter_rate <= 15'd23040;
            r_cfg.view_half_angle   <= 14'd1644;
            r_cfg.switch_margin     <= 14'd429;
            r_cfg.approach_limit    <= 14'd4075;
            r_cfg.leave_window      <= 14'd1215;
            r_cfg.confirm_limit     <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPIN_ENTER:    r_cfg.spin_enter_rate   <= i_cfg_data[RATECFG_W-1:0];
                CFG_CENTER_ENTER:  r_cfg.center_enter_rate <= i_cfg_data[RATECFG_W-1:0];
                CFG_VIEW_HALF:     r_cfg.view_half_angle   <= i_cfg_data[ANGCFG_W-1:0];
                CFG_SWITCH_MARGIN: r_cfg.switch_margin     <= i_cfg_data[ANGCFG_W-1:0];
                CFG_APPROACH:      r_cfg.approach_limit    <= i_cfg_data[ANGCFG_W-1:0];
                CFG_LEAVE_WINDOW:  r_cfg.leave_window      <= i_cfg_data[ANGCFG_W-1:0];
                CFG_CONFIRM_LIMIT: r_cfg.confirm_limit     <= i_cfg_data[STREAK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    // classify incoming request
    sms_front u_front (
        .i_tdata (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_item  (w_front_item)
    );

    // queue between classifier and mode machine
    sms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    // lock resolution, mode machine and result register
    sms_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_item  (w_queue_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

endmodule
`default_nettype wire

// File: sim/spin_mode_and_armor_select_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spin_mode_and_armor_select_test: self-checking bench for the armor selector
// A queue-fed driver offers target updates on the input stream while a
// monitor takes results with random back-pressure. Each accepted request is
// run through a local model of the selector and mode machine, and every
// result is compared with the oldest prediction. Phases change the
// thresholds between runs, including all-zero and near-maximum settings.
// ----------------------------------------------------------------------------
module spin_mode_and_armor_select_test;
    import sms_pkg::*;

    // one target update, offset_a in the lowest bits
    typedef struct packed {
        logic [RATE_W-1:0] spin_rate;
        logic [CNT_W-1:0]  armor_count;
        logic [OFF_W-1:0]  offset_d;
        logic [OFF_W-1:0]  offset_c;
        logic [OFF_W-1:0]  offset_b;
        logic [OFF_W-1:0]  offset_a;
    } t_target_update;

    // one result as seen on tdata and tuser
    typedef struct packed {
        logic             no_armor;
        logic [1:0]       mode_now;
        logic             aim_at_center;
        logic [IDX_W-1:0] chosen_armor;
    } t_armor_choice;

    localparam int PAD_W = IN_DATA_W - $bits(t_target_update);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copies, reset values
    int cfg_spin_enter  = 1536;
    int cfg_center_enter = 23040;
    int cfg_view_half   = 1644;
    int cfg_margin      = 429;
    int cfg_approach    = 4075;
    int cfg_leave       = 1215;
    int cfg_confirm     = 5;

    // tracking state copy
    t_mode mode_q   = MODE_SLOW;
    int    streak_q = 0;
    int    lock_q   = int'(NO_LOCK);

    t_target_update pending_updates[$];
    t_armor_choice  expected_choices[$];
    t_target_update offered;

    int errors = 0;
    int choices_seen = 0;
    bit late_run = 1'b0;
    int drv_idle = 0;
    int drv_calm = 0;
    int mon_calm = 0;
    int mon_stall = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    spin_mode_and_armor_select uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // model of armor pick and mode update for one accepted request
    task automatic predict_choice(input t_target_update u, output t_armor_choice r);
        int    d[4];
        int    mg[4];
        int    n, rate, arate, near, pick, nc, c0, c1, other, i;
        bit    found;
        t_mode was;
        d[0] = $signed(u.offset_a);
        d[1] = $signed(u.offset_b);
        d[2] = $signed(u.offset_c);
        d[3] = $signed(u.offset_d);
        for (i = 0; i < 4; i++) mg[i] = (d[i] < 0) ? -d[i] : d[i];
        rate = $signed(u.spin_rate);
        arate = (rate < 0) ? -rate : rate;
        n = u.armor_count;
        if (n > ACTIVE_SLOTS) n = ACTIVE_SLOTS;
        was = mode_q;
        r.aim_at_center = (was == MODE_CENTER);
        pick = 0;
        if (n == 0) begin
            // nothing to aim at: state untouched
            r.chosen_armor = '0;
            r.mode_now = was;
            r.no_armor = 1'b1;
        end else begin
            near = 0;
            for (i = 1; i < n; i++) if (mg[i] < mg[near]) near = i;
            // armor pick with the mode held before the update
            if (was == MODE_SLOW) begin
                nc = 0;
                c0 = 0;
                c1 = 0;
                for (i = 0; i < n; i++) begin
                    if (mg[i] <= cfg_view_half) begin
                        if (nc == 0) c0 = i;
                        else if (nc == 1) c1 = i;
                        nc++;
                    end
                end
                if (nc == 0) begin
                    lock_q = int'(NO_LOCK);
                    pick = near;
                end else if (nc == 1) begin
                    lock_q = int'(NO_LOCK);
                    pick = c0;
                end else begin
                    if (lock_q != c0 && lock_q != c1)
                        lock_q = (mg[c0] < mg[c1]) ? c0 : c1;
                    other = (lock_q == c0) ? c1 : c0;
                    if (mg[other] < mg[lock_q] - cfg_margin) lock_q = other;
                    pick = lock_q;
                end
            end else if (was == MODE_SPIN) begin
                found = 1'b0;
                for (i = 0; i < n; i++) begin
                    if (!found && mg[i] <= cfg_approach &&
                        ((rate > 0 && d[i] > 0 && d[i] < cfg_leave) ||
                         (rate < 0 && d[i] < 0 && d[i] > -cfg_leave))) begin
                        pick = i;
                        found = 1'b1;
                    end
                end
                if (!found) pick = near;
            end else begin
                pick = near;
            end

            // mode machine, one shared streak counter
            if (was == MODE_SLOW) begin
                if (arate > cfg_spin_enter) begin
                    if (streak_q < STREAK_MAX) streak_q++;
                end else begin
                    streak_q = 0;
                end
                if (streak_q > cfg_confirm) begin
                    mode_q = MODE_SPIN;
                    streak_q = 0;
                    lock_q = int'(NO_LOCK);
                end
            end else if (was == MODE_SPIN) begin
                if (arate > cfg_center_enter) begin
                    if (streak_q < STREAK_MAX) streak_q++;
                    if (streak_q > cfg_confirm) begin
                        mode_q = MODE_CENTER;
                        streak_q = 0;
                    end
                end else if (arate < cfg_spin_enter) begin
                    if (streak_q < STREAK_MAX) streak_q++;
                    if (streak_q > cfg_confirm) begin
                        mode_q = MODE_SLOW;
                        streak_q = 0;
                        lock_q = int'(NO_LOCK);
                    end
                end else begin
                    streak_q = 0;
                end
            end else begin
                if (arate < cfg_center_enter) begin
                    if (streak_q < STREAK_MAX) streak_q++;
                    if (streak_q > cfg_confirm) begin
                        mode_q = MODE_SPIN;
                        streak_q = 0;
                    end
                end else begin
                    streak_q = 0;
                end
            end
            r.chosen_armor = pick[IDX_W-1:0];
            r.mode_now = mode_q;
            r.no_armor = 1'b0;
        end
    endtask

    // random idle burst length, with calm stretches and none late in the run
    task automatic draw_pause(input bit late, inout int calm, output int len);
        len = 0;
        if (!late) begin
            if (calm > 0) calm--;
            else if ($urandom_range(0, 24) == 0) calm = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 12);
        end
    endtask

    // driver: offers queued requests, predicts each one taken
    always @(posedge i_clk) begin : driver
        t_target_update nxt;
        t_armor_choice  want;
        int             len;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            drv_idle <= 0;
        end else begin
            // request taken
            if (s_tvalid && s_tready) begin
                predict_choice(offered, want);
                expected_choices.insert(expected_choices.size(), want);
            end
            // next request or idle
            if (!s_tvalid || s_tready) begin
                if (drv_idle > 0) begin
                    s_tvalid <= 1'b0;
                    drv_idle <= drv_idle - 1;
                end else if (pending_updates.size() != 0) begin
                    nxt = pending_updates.pop_front();
                    offered <= nxt;
                    s_tdata <= {{PAD_W{1'b0}}, nxt};
                    s_tvalid <= 1'b1;
                    draw_pause(late_run, drv_calm, len);
                    drv_idle <= len;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && choices_seen >= 700) begin
            hold_done <= 1'b1;
            hold_left <= 64;
        end
    end

    // monitor: checks results, stalls the output at random
    always @(posedge i_clk) begin : monitor
        t_armor_choice got;
        t_armor_choice want;
        int            len;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            mon_stall <= 0;
        end else begin
            // result check against the oldest prediction
            if (m_tvalid && m_tready) begin
                choices_seen <= choices_seen + 1;
                got.chosen_armor = m_tdata[1:0];
                got.aim_at_center = m_tdata[2];
                got.mode_now = m_tdata[4:3];
                got.no_armor = m_tuser;
                if (expected_choices.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result armor %0d aim %0d mode %0d none %0d",
                             $time, got.chosen_armor, got.aim_at_center, got.mode_now,
                             got.no_armor);
                end else begin
                    want = expected_choices.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $time, want.chosen_armor, want.aim_at_center, want.mode_now,
                                 want.no_armor, got.chosen_armor, got.aim_at_center,
                                 got.mode_now, got.no_armor);
                    end
                end
            end
            // back-pressure: random bursts and one long hold
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (mon_stall > 0) begin
                m_tready <= 1'b0;
                mon_stall <= mon_stall - 1;
            end else begin
                draw_pause(late_run, mon_calm, len);
                if (len > 0) begin
                    m_tready <= 1'b0;
                    mon_stall <= len - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic add_update(input int a, input int b, input int c, input int d,
                              input int cnt, input int rate);
        t_target_update u;
        u.offset_a = a[OFF_W-1:0];
        u.offset_b = b[OFF_W-1:0];
        u.offset_c = c[OFF_W-1:0];
        u.offset_d = d[OFF_W-1:0];
        u.armor_count = cnt[CNT_W-1:0];
        u.spin_rate = rate[RATE_W-1:0];
        pending_updates.insert(pending_updates.size(), u);
    endtask

    // offset drawn near the view, near the leave window, anywhere, or raw
    function automatic int draw_offset(input int rate);
        int r, v;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            v = $urandom_range(0, cfg_view_half + cfg_margin + 2);
            if ($urandom_range(0, 1) == 1) v = -v;
        end else if (r < 6) begin
            v = $urandom_range(0, cfg_leave + 2);
            if ((rate < 0) != ($urandom_range(0, 3) == 0)) v = -v;
        end else if (r < 9) begin
            v = $urandom_range(0, 25736) - 12868;
        end else begin
            v = $urandom_range(0, 32767);
        end
        return v;
    endfunction

    // runs of updates held in one rate band so the streak can build
    task automatic fill_random(input int count);
        int made, run, band, lo, hi, mag, rate, k, r, cnt, cap;
        bit neg, noisy;
        made = 0;
        while (made < count) begin
            cap = (cfg_confirm < 30) ? cfg_confirm : 30;
            run = $urandom_range(1, cap + 8);
            band = $urandom_range(0, 5);
            noisy = ($urandom_range(0, 6) == 0);
            neg = $urandom_range(0, 1);
            case (band)
                0: begin lo = 0; hi = (cfg_spin_enter > 0) ? cfg_spin_enter - 1 : 0; end
                1: begin lo = cfg_spin_enter; hi = cfg_spin_enter; end
                2: begin lo = cfg_spin_enter + 1; hi = cfg_center_enter - 1; end
                3: begin lo = cfg_center_enter; hi = cfg_center_enter; end
                4: begin lo = cfg_center_enter + 1; hi = 32768; end
                default: begin lo = 0; hi = 32768; end
            endcase
            if (lo > hi) begin
                lo = cfg_spin_enter;
                hi = cfg_spin_enter;
            end
            for (k = 0; k < run && made < count; k++) begin
                if (noisy) begin
                    rate = $urandom_range(0, 65535) - 32768;
                end else begin
                    if ($urandom_range(0, 7) == 0) neg = !neg;
                    mag = $urandom_range(lo, hi);
                    rate = neg ? -mag : mag;
                    if (rate > 32767) rate = -32768;
                end
                r = $urandom_range(0, 19);
                if (r == 0) cnt = 0;
                else if (r == 1) cnt = $urandom_range(5, 7);
                else cnt = $urandom_range(1, 4);
                add_update(draw_offset(rate), draw_offset(rate), draw_offset(rate),
                           draw_offset(rate), cnt, rate);
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_SPIN_ENTER:    cfg_spin_enter = value & 32'h7FFF;
            CFG_CENTER_ENTER:  cfg_center_enter = value & 32'h7FFF;
            CFG_VIEW_HALF:     cfg_view_half = value & 32'h3FFF;
            CFG_SWITCH_MARGIN: cfg_margin = value & 32'h3FFF;
            CFG_APPROACH:      cfg_approach = value & 32'h3FFF;
            CFG_LEAVE_WINDOW:  cfg_leave = value & 32'h3FFF;
            CFG_CONFIRM_LIMIT: cfg_confirm = value & 32'hFF;
            default: ;
        endcase
    endtask

    task automatic load_settings(input int se, input int ce, input int vh, input int sm,
                                 input int al, input int lw, input int cl);
        write_reg(CFG_SPIN_ENTER, se);
        write_reg(CFG_CENTER_ENTER, ce);
        write_reg(CFG_VIEW_HALF, vh);
        write_reg(CFG_SWITCH_MARGIN, sm);
        write_reg(CFG_APPROACH, al);
        write_reg(CFG_LEAVE_WINDOW, lw);
        write_reg(CFG_CONFIRM_LIMIT, cl);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // block idle: queue empty, nothing offered, every result back
    task automatic wait_drained;
        @(negedge i_clk);
        while (pending_updates.size() != 0 || s_tvalid || expected_choices.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin : stimulus
        int p, se;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed updates at reset thresholds
        add_update(0, 0, 0, 0, 0, 0);                      // no armor
        add_update(12868, -12868, 16383, -16384, 7, 0);    // count saturates, tie
        add_update(-16384, 100, -100, 5, 4, 0);            // two in view, tie locks second
        add_update(-16384, 300, -900, 5, 4, 0);            // other steals the lock
        add_update(0, 1000, 600, 0, 5, -1536);
        add_update(1644, -1644, 0, 0, 2, 1537);            // view limit inclusive
        add_update(1700, -1645, 0, 0, 2, -1537);           // none in view
        add_update(200, 0, 0, 0, 1, 32767);
        add_update(-500, -600, 0, 0, 3, -32768);
        add_update(0, 0, 0, 0, 0, 20000);                  // no armor keeps the streak
        add_update(300, -300, 0, 0, 2, 2000);
        add_update(300, -300, 0, 0, 2, 2000);              // enters spinning
        add_update(2000, 500, 100, -300, 4, 1600);
        add_update(-1214, -1215, 300, 4076, 4, -1600);
        add_update(1215, -1214, 100, 0, 4, 1600);          // leave window exclusive
        add_update(100, 50, -20, 4000, 4, 0);              // zero rate, streak toward slow
        add_update(-30, 4100, 1000, -1000, 4, 23041);      // shared streak toward centre
        add_update(4100, -30, 1000, -1000, 3, -23041);
        add_update(900, 900, -900, 1, 4, 30000);
        add_update(-1, 1, 2, -2, 4, -30000);
        add_update(600, -700, 800, -900, 4, 23041);        // enters centre
        add_update(5, -5, 7, 3, 4, 23040);
        add_update(0, 0, 0, 0, 0, -32768);
        add_update(-12868, 12868, -1, 2, 3, -32768);
        fill_random(230);

        // phases with new thresholds, extremes first
        for (p = 0; p < 7; p++) begin
            wait_drained();
            case (p)
                0: load_settings(0, 0, 0, 0, 0, 0, 0);
                1: load_settings(32767, 32767, 16383, 16383, 16383, 16383, 1);
                2: load_settings(32767, 32767, 12868, 12868, 12868, 12868, 255);
                3: load_settings(1536, 23040, 1644, 429, 4075, 1215, 254);
                default: begin
                    se = $urandom_range(0, 8000);
                    load_settings(se, $urandom_range(se, 32767), $urandom_range(0, 4000),
                                  $urandom_range(0, 1500), $urandom_range(0, 8000),
                                  $urandom_range(0, 4000), $urandom_range(0, 8));
                end
            endcase
            @(negedge i_clk);
            fill_random((p == 3) ? 120 : 230);
        end

        // last part without idling on either side
        wait_drained();
        load_settings(1536, 23040, 1644, 429, 4075, 1215, 2);
        @(negedge i_clk);
        late_run = 1'b1;
        fill_random(200);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run time limit
    initial begin : watchdog
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/sms_pkg.sv
hdl/sms_front.sv
hdl/sms_queue.sv
hdl/sms_back.sv
hdl/spin_mode_and_armor_select.sv
sim/spin_mode_and_armor_select_test.sv
